// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the LCS length and traceback engine.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CHAR_W      = 8;
  localparam int REQ_W       = 2;
  localparam int LEN_W       = 7;

  // request codes carried on in_req_type
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FILL_RD,
    S_FILL_WR,
    S_TB_RD,
    S_TB_STEP,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic launch;
    logic fill_issue;
    logic fill_write;
    logic tb_issue;
    logic tb_step;
    logic emit_issue;
    logic emit_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic fill_last;
    logic tb_end;
    logic emit_last;
  } sts_t;

endpackage

// ===== rtl/lcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: loads, table fill, traceback and result emission.
// ----------------------------------------------------------------------------
module lcs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lcs_pkg::REQ_W-1:0]   in_req_type,
  input  lcs_pkg::sts_t               sts,
  output lcs_pkg::cmd_t               cmd,
  output logic                        busy
);
  import lcs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (in_req_type)
            REQ_LOAD_A: cmd.load_a = 1'b1;
            REQ_LOAD_B: cmd.load_b = 1'b1;
            REQ_START: begin
              cmd.launch = 1'b1;
              state_nxt  = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        state_nxt = sts.empty ? S_EMIT_RD : S_FILL_RD;
      end
      S_FILL_RD: begin
        cmd.fill_issue = 1'b1;
        state_nxt      = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_write = 1'b1;
        state_nxt      = sts.fill_last ? S_TB_RD : S_FILL_RD;
      end
      S_TB_RD: begin
        if (sts.tb_end) begin
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.tb_issue = 1'b1;
          state_nxt    = S_TB_STEP;
        end
      end
      S_TB_STEP: begin
        cmd.tb_step = 1'b1;
        state_nxt   = S_TB_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_issue = 1'b1;
        state_nxt      = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.emit_out = 1'b1;
        state_nxt    = sts.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lcs_dp.sv =====
// ----------------------------------------------------------------------------
// lcs_dp
// String stores, score row buffer, direction table, result buffer and the
// fill / traceback / emit counters.
// ----------------------------------------------------------------------------
module lcs_dp #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcs_pkg::cmd_t               cmd,
  input  logic [lcs_pkg::CHAR_W-1:0]  in_symbol,
  output lcs_pkg::sts_t               sts,
  output logic [lcs_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_char_valid,
  output logic [lcs_pkg::LEN_W-1:0]   out_lcs_length,
  output logic                        out_truncated,
  output logic                        out_last
);
  import lcs_pkg::*;

  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DIR_D = 1 << (2 * AW);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // storage
  logic [CHAR_W-1:0] a_mem   [0:MAX_LEN-1];
  logic [CHAR_W-1:0] b_mem   [0:MAX_LEN-1];
  logic [CW-1:0]     row_mem [0:MAX_LEN-1];
  logic [1:0]        dir_mem [0:DIR_D-1];
  logic [CHAR_W-1:0] res_mem [0:MAX_LEN-1];

  logic [CW-1:0]     cnt_a_r, cnt_b_r;
  logic              ovf_r, trunc_r;
  logic [CW-1:0]     rows_r, cols_r, i_r, j_r;
  logic [CW-1:0]     left_r, diag_r, len_r, pos_r, k_r;
  logic [CW-1:0]     up_q;
  logic [CHAR_W-1:0] a_q, b_q, res_q;
  logic [1:0]        dir_q;

  logic [CW-1:0]     im1, jm1, pm1, up_v, best, val;
  logic              match, up_ge;
  logic [2*AW-1:0]   dir_addr;

  assign im1      = i_r - ONE;
  assign jm1      = j_r - ONE;
  assign pm1      = pos_r - ONE;
  assign dir_addr = {im1[AW-1:0], jm1[AW-1:0]};

  // cell score: first row sees zeros above it
  assign up_v  = (i_r == ONE) ? '0 : up_q;
  assign match = (a_q == b_q);
  assign up_ge = (up_v >= left_r);
  assign best  = up_ge ? up_v : left_r;
  assign val   = match ? (diag_r + ONE) : best;

  assign sts.empty     = (rows_r == '0) || (cols_r == '0);
  assign sts.fill_last = (i_r == rows_r) && (j_r == cols_r);
  assign sts.tb_end    = (i_r == '0) || (j_r == '0);
  assign sts.emit_last = (len_r == '0) || (k_r == len_r - ONE);

  // load counters and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.launch) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load_a) begin
      if (cnt_a_r < MAX_CNT) begin
        cnt_a_r <= cnt_a_r + ONE;
      end else begin
        ovf_r <= 1'b1;
      end
    end else if (cmd.load_b) begin
      if (cnt_b_r < MAX_CNT) begin
        cnt_b_r <= cnt_b_r + ONE;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // string stores
  always_ff @(posedge clk) begin
    if (cmd.load_a && (cnt_a_r < MAX_CNT)) begin
      a_mem[cnt_a_r[AW-1:0]] <= in_symbol;
    end
    if (cmd.fill_issue || cmd.tb_issue) begin
      a_q <= a_mem[im1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b && (cnt_b_r < MAX_CNT)) begin
      b_mem[cnt_b_r[AW-1:0]] <= in_symbol;
    end
    if (cmd.fill_issue) begin
      b_q <= b_mem[jm1[AW-1:0]];
    end
  end

  // previous-row scores
  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      row_mem[jm1[AW-1:0]] <= val;
    end
    if (cmd.fill_issue) begin
      up_q <= row_mem[jm1[AW-1:0]];
    end
  end

  // per-cell step direction: {match, up >= left}
  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      dir_mem[dir_addr] <= {match, up_ge};
    end
    if (cmd.tb_issue) begin
      dir_q <= dir_mem[dir_addr];
    end
  end

  // result characters, filled back to front
  always_ff @(posedge clk) begin
    if (cmd.tb_step && dir_q[1]) begin
      res_mem[pm1[AW-1:0]] <= a_q;
    end
    if (cmd.emit_issue) begin
      res_q <= res_mem[k_r[AW-1:0]];
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      rows_r  <= cnt_a_r;
      cols_r  <= cnt_b_r;
      trunc_r <= ovf_r;
      i_r     <= ONE;
      j_r     <= ONE;
      left_r  <= '0;
      diag_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      k_r     <= '0;
    end else if (cmd.fill_write) begin
      if (sts.fill_last) begin
        // hand the corner over to traceback
        len_r <= val;
        pos_r <= val;
        i_r   <= rows_r;
        j_r   <= cols_r;
      end else if (j_r == cols_r) begin
        i_r    <= i_r + ONE;
        j_r    <= ONE;
        left_r <= '0;
        diag_r <= '0;
      end else begin
        j_r    <= j_r + ONE;
        left_r <= val;
        diag_r <= up_v;
      end
    end else if (cmd.tb_step) begin
      if (dir_q[1]) begin
        i_r   <= im1;
        j_r   <= jm1;
        pos_r <= pm1;
      end else if (dir_q[0]) begin
        i_r <= im1;
      end else begin
        j_r <= jm1;
      end
    end else if (cmd.emit_out) begin
      k_r <= k_r + ONE;
    end
  end

  assign out_char_valid = (len_r != '0);
  assign out_char       = out_char_valid ? res_q : '0;
  assign out_lcs_length = LEN_W'(len_r);
  assign out_truncated  = trunc_r;
  assign out_last       = sts.emit_last;

endmodule

// ===== rtl/lcs_length_and_traceback_top.sv =====
// Sequence: a load item is handled in the idle state. A start item runs a
// check state, table fill (a read and a write state per cell), traceback (a
// read and a step state per step, at most rows + cols - 1 steps, then a read
// state that sees the walk end) and emission (a read, an output per result).
// busy stays high from the start transfer to the last result; the receiver
// cannot stall. Reset (rst_n low, synchronous) clears sequencer, counts, flag.
// ----------------------------------------------------------------------------
// lcs_length_and_traceback_top
// Longest common subsequence engine: loads two strings, fills the score
// table row by row and traces back to emit the subsequence in order.
// ----------------------------------------------------------------------------
module lcs_length_and_traceback_top #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lcs_pkg::REQ_W-1:0]   in_req_type,
  input  logic [lcs_pkg::CHAR_W-1:0]  in_symbol,
  output logic                        out_strobe,
  output logic [lcs_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_char_valid,
  output logic [lcs_pkg::LEN_W-1:0]   out_lcs_length,
  output logic                        out_truncated,
  output logic                        out_last
);
  import lcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  lcs_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_symbol      (in_symbol),
    .sts            (sts),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_lcs_length (out_lcs_length),
    .out_truncated  (out_truncated),
    .out_last       (out_last)
  );

  assign out_strobe = cmd.emit_out;

endmodule

// ===== rtl/lcs_checker.sv =====
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks on the LCS engine, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [lcs_pkg::REQ_W-1:0]   in_req_type,
  input logic                        out_strobe,
  input logic                        out_char_valid,
  input logic [lcs_pkg::LEN_W-1:0]   out_lcs_length,
  input logic                        out_last
);
  import lcs_pkg::*;

  // a start transfer holds off further input
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_START)) |=> busy)
    else $error("busy not raised after start transfer");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobed while idle");

  // empty result is a single closing item of length zero
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_char_valid) |-> (out_last && (out_lcs_length == '0)))
    else $error("malformed empty result");

  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_char_valid) |-> (out_lcs_length != '0))
    else $error("character result with zero length");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> (!busy && !out_strobe))
    else $error("engine still busy after last result");

endmodule

bind lcs_length_and_traceback_top lcs_checker u_lcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_strobe     (out_strobe),
  .out_char_valid (out_char_valid),
  .out_lcs_length (out_lcs_length),
  .out_last       (out_last)
);
